FILE: rtl/sssu_pkg.sv
// Shared types, constants and the segment table for the seven-segment scan unit.
package sssu_pkg;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REFRESH = 1'b1;

    localparam int FRAME_BITS = 16;
    localparam int CNT_W      = 4;     // counts the bits of one frame
    localparam int POS_W      = 2;     // digit position, also the digit counter width
    localparam int MAX_DIGITS = 4;

    localparam logic [7:0] SEL_BASE  = 8'hF0;
    localparam logic [7:0] SEG_BLANK = 8'hFF;

    typedef struct packed {
        logic        op;
        logic [15:0] number_in;
    } sssu_in_t;

    typedef struct packed {
        logic             serial_bit;
        logic             latch_pulse;
        logic [POS_W-1:0] digit_index;
        logic             last;
    } sssu_out_t;

    // Active-low segment pattern of one decimal digit
    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'hC0;
            4'd1:    pat = 8'hF9;
            4'd2:    pat = 8'hA4;
            4'd3:    pat = 8'hB0;
            4'd4:    pat = 8'h99;
            4'd5:    pat = 8'h92;
            4'd6:    pat = 8'h82;
            4'd7:    pat = 8'hF8;
            4'd8:    pat = 8'h80;
            4'd9:    pat = 8'h90;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

endpackage

FILE: rtl/sssu_bcd.sv
// Bit-serial binary to BCD converter (shift and add three), one input bit per cycle.
module sssu_bcd #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [15:0]              number_in,
    output logic                     busy,
    output logic [4*DIGIT_COUNT-1:0] bcd,
    output logic                     overflow
);

    localparam int BCD_W = 4 * DIGIT_COUNT;

    logic [15:0]            bin_reg,  bin_next;
    logic [BCD_W-1:0]       bcd_reg,  bcd_next;
    logic                   ovf_reg,  ovf_next;
    logic [sssu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic [BCD_W-1:0]       adj;

    // Add three to every digit that is five or more
    always_comb
    begin
        for (int j = 0; j < DIGIT_COUNT; j++)
        begin
            if (bcd_reg[j*4 +: 4] >= 4'd5)
                adj[j*4 +: 4] = bcd_reg[j*4 +: 4] + 4'd3;
            else
                adj[j*4 +: 4] = bcd_reg[j*4 +: 4];
        end
    end

    // Start on request, then shift one binary bit in per cycle
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            bin_next  = number_in;
            bcd_next  = '0;
            ovf_next  = 1'b0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // a bit leaving the top digit means the value needs more digits
            ovf_next = ovf_reg | adj[BCD_W-1];
            bcd_next = {adj[BCD_W-2:0], bin_reg[15]};
            bin_next = {bin_reg[14:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sssu_pkg::CNT_W'(sssu_pkg::FRAME_BITS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_reg  <= '0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            bcd_reg  <= bcd_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // Binary shifter is payload only
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
    end

    assign busy     = busy_reg;
    assign bcd      = bcd_reg;
    assign overflow = ovf_reg;

endmodule

FILE: rtl/seven_segment_serial_scan_unit.sv
// Top level of the seven-segment serial scan unit: command intake, frame serializer, output register.
// A load beat stores a 16-bit number and converts it to decimal, during which in_ready is low; it
// produces no output beats. A refresh beat sends one 16-bit frame per shown digit, ones digit
// first, one output beat per cycle while out_ready stays high. Each frame is the active-low segment
// byte then the digit-select byte, both MSB first; latch_pulse marks the frame's final bit and last
// marks the final bit of the run. Leading zero digits are not sent, values of 10000 and above show
// their low four decimal digits, and at most DIGIT_COUNT digits are sent. The next beat is taken
// once the last bit of a run sits in the output register.
module seven_segment_serial_scan_unit #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sssu_pkg::sssu_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sssu_pkg::sssu_out_t out_data
);

    localparam int BCD_W = 4 * DIGIT_COUNT;
    localparam int POS_W = sssu_pkg::POS_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                       state_reg,  state_next;
    logic [POS_W-1:0]           k_reg,      k_next;
    logic [POS_W-1:0]           kmax_reg,   kmax_next;
    logic [sssu_pkg::CNT_W-1:0] bit_reg,    bit_next;
    logic [sssu_pkg::FRAME_BITS-1:0] frame_reg, frame_next;
    logic                       oval_reg,   oval_next;
    sssu_pkg::sssu_out_t        odata_reg,  odata_next;

    logic                       in_acc;
    logic                       conv_start;
    logic                       conv_busy;
    logic [BCD_W-1:0]           bcd;
    logic                       overflow;
    logic [POS_W-1:0]           ndig_m1;
    logic                       hit;
    logic [POS_W-1:0]           build_k;
    logic [3:0]                 build_digit;
    logic [POS_W-1:0]           build_pos;
    logic [sssu_pkg::FRAME_BITS-1:0] build_frame;
    logic                       advance;
    logic                       frame_end;

    assign in_ready   = (state_reg == ST_IDLE) && !conv_busy;
    assign in_acc     = in_valid && in_ready;
    assign conv_start = in_acc && (in_data.op == sssu_pkg::OP_LOAD);

    sssu_bcd #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (conv_start),
        .number_in (in_data.number_in),
        .busy      (conv_busy),
        .bcd       (bcd),
        .overflow  (overflow)
    );

    // Find the highest digit to send: the value reaches 10^j when any digit at j or above is set
    always_comb
    begin
        ndig_m1 = '0;
        hit     = overflow;
        for (int j = DIGIT_COUNT - 1; j >= 1; j--)
        begin
            hit = hit | (bcd[j*4 +: 4] != 4'd0);
            if (hit && (ndig_m1 == '0))
                ndig_m1 = POS_W'(j);
        end
    end

    // Build the frame of the digit that goes out next
    assign build_k = (state_reg == ST_IDLE) ? '0 : k_reg + 1'b1;

    always_comb
    begin
        build_digit = '0;
        for (int j = 0; j < DIGIT_COUNT; j++)
        begin
            if (build_k == POS_W'(j))
                build_digit = bcd[j*4 +: 4];
        end
    end

    assign build_pos   = POS_W'(sssu_pkg::MAX_DIGITS - 1) - build_k;
    assign build_frame = {sssu_pkg::seg_pattern(build_digit),
                          sssu_pkg::SEL_BASE | (8'd1 << build_pos)};

    assign advance   = (state_reg == ST_SCAN) && (!oval_reg || out_ready);
    assign frame_end = (bit_reg == sssu_pkg::CNT_W'(sssu_pkg::FRAME_BITS - 1));

    // Sequence the scan: start a run, shift one bit per beat, move to the next frame
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        kmax_next  = kmax_reg;
        bit_next   = bit_reg;
        frame_next = frame_reg;
        oval_next  = oval_reg;
        odata_next = odata_reg;

        if (out_ready)
            oval_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_data.op == sssu_pkg::OP_REFRESH))
                begin
                    state_next = ST_SCAN;
                    k_next     = '0;
                    kmax_next  = ndig_m1;
                    bit_next   = '0;
                    frame_next = build_frame;
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    oval_next              = 1'b1;
                    odata_next.serial_bit  = frame_reg[sssu_pkg::FRAME_BITS-1];
                    odata_next.latch_pulse = frame_end;
                    odata_next.digit_index = POS_W'(sssu_pkg::MAX_DIGITS - 1) - k_reg;
                    odata_next.last        = frame_end && (k_reg == kmax_reg);
                    frame_next = {frame_reg[sssu_pkg::FRAME_BITS-2:0], 1'b0};
                    bit_next   = bit_reg + 1'b1;
                    if (frame_end)
                    begin
                        if (k_reg == kmax_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            k_next     = k_reg + 1'b1;
                            frame_next = build_frame;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            kmax_reg  <= '0;
            bit_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            kmax_reg  <= kmax_next;
            bit_reg   <= bit_next;
            oval_reg  <= oval_next;
        end
    end

    // Frame shifter and output payload
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        odata_reg <= odata_next;
    end

    assign out_valid = oval_reg;
    assign out_data  = odata_reg;

endmodule

FILE: rtl/sssu_checker.sv
// Port-level checks of the seven-segment scan unit and their binding to the top level.
module sssu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input sssu_pkg::sssu_in_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input sssu_pkg::sssu_out_t out_data
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat dropped or changed while stalled");

    // End of run always closes a frame
    a_last_latch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> out_data.latch_pulse)
        else $error("last without latch pulse");

    // Refresh blocks further input while it runs
    a_refresh_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.op == sssu_pkg::OP_REFRESH) |=> !in_ready)
        else $error("input taken during a refresh run");

    // Load creates no output beat
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.op == sssu_pkg::OP_LOAD) && !out_valid
        |=> !out_valid)
        else $error("output beat after a load");

endmodule

bind seven_segment_serial_scan_unit sssu_checker u_sssu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
